// ----- src/b64d_pkg.sv -----
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and lookup tables of the base64 stream decoder
// Holds the queue entry format, queue status bundle and both alphabet ROMs.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int B64D_QUEUE_DEPTH = 4;

  localparam logic [7:0] PAD_CHAR  = 8'h3D;
  localparam logic [7:0] ASCII_MAX = 8'd127;

  localparam logic ALPHA_STD  = 1'b0;
  localparam logic ALPHA_PERM = 1'b1;

  typedef struct packed {
    logic       hit;
    logic [5:0] sextet;
  } b64d_lookup_t;

  // One queue entry: up to three result bytes of one request.
  typedef struct packed {
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [1:0] cnt;
    logic       error;
    logic       last;
  } b64d_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64d_qstat_t;

  function automatic b64d_lookup_t b64d_std_lookup(input logic [7:0] c);
    b64d_lookup_t r;
    r.hit    = 1'b1;
    r.sextet = 6'd0;
    if (c >= "A" && c <= "Z") begin
      r.sextet = 6'(c - 8'h41);
    end else if (c >= "a" && c <= "z") begin
      r.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= "0" && c <= "9") begin
      r.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == "+") begin
      r.sextet = 6'd62;
    end else if (c == "/") begin
      r.sextet = 6'd63;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

  // Inverse of the permuted alphabet ROM.
  function automatic b64d_lookup_t b64d_perm_lookup(input logic [7:0] c);
    b64d_lookup_t r;
    r.hit = 1'b1;
    unique case (c)
      "U": r.sextet = 6'd0;   "M": r.sextet = 6'd1;   "g": r.sextet = 6'd2;
      "h": r.sextet = 6'd3;   "A": r.sextet = 6'd4;   "B": r.sextet = 6'd5;
      "C": r.sextet = 6'd6;   "u": r.sextet = 6'd7;   "v": r.sextet = 6'd8;
      "w": r.sextet = 6'd9;   "x": r.sextet = 6'd10;  "y": r.sextet = 6'd11;
      "S": r.sextet = 6'd12;  "T": r.sextet = 6'd13;  "d": r.sextet = 6'd14;
      "L": r.sextet = 6'd15;  "3": r.sextet = 6'd16;  "b": r.sextet = 6'd17;
      "c": r.sextet = 6'd18;  "V": r.sextet = 6'd19;  "t": r.sextet = 6'd20;
      "p": r.sextet = 6'd21;  "0": r.sextet = 6'd22;  "Y": r.sextet = 6'd23;
      "Z": r.sextet = 6'd24;  "G": r.sextet = 6'd25;  "H": r.sextet = 6'd26;
      "k": r.sextet = 6'd27;  "l": r.sextet = 6'd28;  "/": r.sextet = 6'd29;
      "z": r.sextet = 6'd30;  "n": r.sextet = 6'd31;  "o": r.sextet = 6'd32;
      "8": r.sextet = 6'd33;  "9": r.sextet = 6'd34;  "+": r.sextet = 6'd35;
      "K": r.sextet = 6'd36;  "W": r.sextet = 6'd37;  "X": r.sextet = 6'd38;
      "O": r.sextet = 6'd39;  "R": r.sextet = 6'd40;  "e": r.sextet = 6'd41;
      "f": r.sextet = 6'd42;  "a": r.sextet = 6'd43;  "1": r.sextet = 6'd44;
      "2": r.sextet = 6'd45;  "i": r.sextet = 6'd46;  "j": r.sextet = 6'd47;
      "5": r.sextet = 6'd48;  "6": r.sextet = 6'd49;  "7": r.sextet = 6'd50;
      "I": r.sextet = 6'd51;  "J": r.sextet = 6'd52;  "m": r.sextet = 6'd53;
      "q": r.sextet = 6'd54;  "r": r.sextet = 6'd55;  "s": r.sextet = 6'd56;
      "N": r.sextet = 6'd57;  "P": r.sextet = 6'd58;  "Q": r.sextet = 6'd59;
      "4": r.sextet = 6'd60;  "D": r.sextet = 6'd61;  "E": r.sextet = 6'd62;
      "F": r.sextet = 6'd63;
      default: begin
        r.hit    = 1'b0;
        r.sextet = 6'd0;
      end
    endcase
    return r;
  endfunction

  function automatic b64d_lookup_t b64d_lookup(input logic [7:0] c, input logic sel);
    b64d_lookup_t r;
    if (sel == ALPHA_PERM) begin
      r = b64d_perm_lookup(c);
    end else begin
      r = b64d_std_lookup(c);
    end
    if (c == 8'd0 || c > ASCII_MAX) begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

// ----- src/b64d_in_if.sv -----
// ----------------------------------------------------------------------------
// b64d_in_if: character channel of the base64 stream decoder
// Valid/ready channel carrying one encoded character and its end flag.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       msg_end;

  modport source (output valid, output ch, output msg_end, input ready);
  modport sink   (input valid, input ch, input msg_end, output ready);
endinterface

// ----- src/b64d_out_if.sv -----
// ----------------------------------------------------------------------------
// b64d_out_if: result channel of the base64 stream decoder
// Valid/ready channel carrying one decoded byte with error and last flags.
// ----------------------------------------------------------------------------
interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       error;
  logic       last;

  modport source (output valid, output data_byte, output error, output last, input ready);
  modport sink   (input valid, input data_byte, input error, input last, output ready);
endinterface

// ----- src/b64d_cfg_if.sv -----
// ----------------------------------------------------------------------------
// b64d_cfg_if: configuration write channel of the base64 stream decoder
// Valid/ready channel carrying the alphabet select register value.
// ----------------------------------------------------------------------------
interface b64d_cfg_if;
  logic valid;
  logic ready;
  logic alphabet_select;

  modport source (output valid, output alphabet_select, input ready);
  modport sink   (input valid, input alphabet_select, output ready);
endinterface

// ----- src/b64d_front.sv -----
// ----------------------------------------------------------------------------
// b64d_front: character classifier and group collector
// Looks up each character, gathers groups of four and queues result requests.
// ----------------------------------------------------------------------------
module b64d_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 alpha_sel,
  b64d_in_if.sink              in_chan,
  input  b64d_pkg::b64d_qstat_t qstat,
  output logic                 push,
  output b64d_pkg::b64d_entry_t push_entry
);
  import b64d_pkg::*;

  logic [1:0]   pos_r, pos_nxt;
  logic [17:0]  held_r, held_nxt;
  logic         tpad_r, tpad_nxt;
  logic         disc_r, disc_nxt;
  logic         acc;
  logic         pad;
  b64d_lookup_t lk;
  b64d_entry_t  err_entry;

  assign in_chan.ready = !qstat.full;
  assign acc = in_chan.valid && in_chan.ready;
  assign lk  = b64d_lookup(in_chan.ch, alpha_sel);
  assign pad = (in_chan.ch == PAD_CHAR);

  always_comb begin
    err_entry       = '0;
    err_entry.cnt   = 2'd1;
    err_entry.error = 1'b1;
    err_entry.last  = 1'b1;
  end

  always_comb begin
    pos_nxt    = pos_r;
    held_nxt   = held_r;
    tpad_nxt   = tpad_r;
    disc_nxt   = disc_r;
    push       = 1'b0;
    push_entry = err_entry;
    if (acc) begin
      if (disc_r) begin
        if (in_chan.msg_end) begin
          disc_nxt = 1'b0;
          pos_nxt  = 2'd0;
          held_nxt = '0;
          tpad_nxt = 1'b0;
        end
      end else if (!(lk.hit || (pad && pos_r[1]))) begin
        push     = 1'b1;
        pos_nxt  = 2'd0;
        held_nxt = '0;
        tpad_nxt = 1'b0;
        disc_nxt = !in_chan.msg_end;
      end else if (pos_r != 2'd3) begin
        case (pos_r)
          2'd0: held_nxt[17:12] = lk.sextet;
          2'd1: held_nxt[11:6]  = lk.sextet;
          default: begin
            // A pad in the third place leaves its sextet at zero.
            if (lk.hit) begin
              held_nxt[5:0] = lk.sextet;
            end
            tpad_nxt = pad;
          end
        endcase
        pos_nxt = pos_r + 2'd1;
        if (in_chan.msg_end) begin
          push     = 1'b1;
          pos_nxt  = 2'd0;
          held_nxt = '0;
          tpad_nxt = 1'b0;
        end
      end else begin
        push             = 1'b1;
        push_entry.byte0 = {held_r[17:12], held_r[11:10]};
        push_entry.byte1 = {held_r[9:6], held_r[5:2]};
        push_entry.byte2 = {held_r[1:0], lk.sextet};
        push_entry.cnt   = tpad_r ? 2'd1 : (pad ? 2'd2 : 2'd3);
        push_entry.error = 1'b0;
        push_entry.last  = in_chan.msg_end;
        pos_nxt          = 2'd0;
        held_nxt         = '0;
        tpad_nxt         = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 2'd0;
      held_r <= '0;
      tpad_r <= 1'b0;
      disc_r <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      held_r <= held_nxt;
      tpad_r <= tpad_nxt;
      disc_r <= disc_nxt;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full) else $error("request pushed into a full queue");
  a_disc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    disc_r |-> (pos_r == 2'd0 && held_r == 18'd0))
    else $error("group not cleared while dropping a message");
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (push && push_entry.error) |-> (push_entry.last && push_entry.cnt == 2'd1
                                    && push_entry.byte0 == 8'd0))
    else $error("error request is not a single final zero byte");
endmodule

// ----- src/b64d_queue.sv -----
// ----------------------------------------------------------------------------
// b64d_queue: request queue between front and back
// Small flop-based first-in first-out buffer of decoded result requests.
// ----------------------------------------------------------------------------
module b64d_queue #(
  parameter int DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  b64d_pkg::b64d_entry_t push_entry,
  input  logic                  pop,
  output b64d_pkg::b64d_entry_t head,
  output b64d_pkg::b64d_qstat_t qstat
);
  import b64d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  b64d_entry_t   mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign qstat.full  = (count_r == CW'(DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
    (qstat.empty || qstat.full) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with count");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> !qstat.empty) else $error("push lost in queue");
endmodule

// ----- src/b64d_back.sv -----
// ----------------------------------------------------------------------------
// b64d_back: result sequencer
// Takes queued requests and delivers their one to three bytes one per cycle while the output channel accepts them.
// ----------------------------------------------------------------------------
module b64d_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  b64d_pkg::b64d_entry_t head,
  input  b64d_pkg::b64d_qstat_t qstat,
  output logic                  pop,
  b64d_out_if.source            out_chan
);
  import b64d_pkg::*;

  b64d_entry_t cur_r, cur_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        busy_r, busy_nxt;
  logic        fire;
  logic        final_byte;
  logic        done;

  assign fire       = out_chan.valid && out_chan.ready;
  assign final_byte = (idx_r == cur_r.cnt - 2'd1);
  assign done       = fire && final_byte;
  assign pop        = (!busy_r || done) && !qstat.empty;

  assign out_chan.valid = busy_r;
  assign out_chan.error = cur_r.error;
  assign out_chan.last  = cur_r.last && final_byte;

  always_comb begin
    case (idx_r)
      2'd0:    out_chan.data_byte = cur_r.byte0;
      2'd1:    out_chan.data_byte = cur_r.byte1;
      default: out_chan.data_byte = cur_r.byte2;
    endcase
  end

  always_comb begin
    cur_nxt  = cur_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (pop) begin
      cur_nxt  = head;
      idx_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (fire) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= 2'd0;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (idx_r < cur_r.cnt)) else $error("byte index past request size");
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cur_r.cnt != 2'd0)) else $error("empty request in sequencer");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && cur_r.error) |-> (out_chan.data_byte == 8'd0 && out_chan.last))
    else $error("error result carries data or misses last");
endmodule

// ----- src/base64_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 decoder, one character per request
// Front classifier, request queue and result sequencer.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while the queue is not full; result bytes
//   leave one per cycle while the output channel accepts them, and four
//   characters give at most three bytes, offered once queued and registered in the sequencer.
// Reset (synchronous, rst_n low) clears the group state, the queue, the
//   sequencer and selects the standard alphabet.
module base64_stream_decoder #(
  parameter int QUEUE_DEPTH = b64d_pkg::B64D_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  b64d_in_if.sink     in_chan,
  b64d_out_if.source  out_chan,
  b64d_cfg_if.sink    cfg_chan
);
  import b64d_pkg::*;

  logic        alpha_sel_r, alpha_sel_nxt;
  logic        push;
  logic        pop;
  b64d_entry_t push_entry;
  b64d_entry_t head;
  b64d_qstat_t qstat;

  assign cfg_chan.ready = 1'b1;
  assign alpha_sel_nxt  = (cfg_chan.valid && cfg_chan.ready) ? cfg_chan.alphabet_select
                                                             : alpha_sel_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_sel_r <= ALPHA_STD;
    end else begin
      alpha_sel_r <= alpha_sel_nxt;
    end
  end

  b64d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .alpha_sel  (alpha_sel_r),
    .in_chan    (in_chan),
    .qstat      (qstat),
    .push       (push),
    .push_entry (push_entry)
  );

  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  b64d_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .out_chan (out_chan)
  );
endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the base64 stream decoder
// Drives character requests in random bursts, stalls the result side, and
// compares every decoded byte against a cycle-free decoder in a scoreboard,
// over both alphabets, padded, truncated and invalid messages.
// ----------------------------------------------------------------------------
module testbench;
  import b64d_pkg::*;

  localparam string STD_ALPHA =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam string PERM_ALPHA =
    "UMghABCuvwxySTdL3bcVtp0YZGHkl/zno89+KWXORefa12ij567IJmqrsNPQ4DEF";

  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int CHARS_PER_PHASE = 36;
  localparam int NUM_PHASES      = 6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       error;
    logic       last;
  } dec_byte_t;

  class byte_scoreboard;
    logic       alpha_sel;
    logic [1:0] group_pos;
    logic [17:0] held_sextets;
    logic       third_is_pad;
    logic       discarding;
    dec_byte_t  expected_bytes[$];
    int         mismatches;
    int         decoded_chars;

    function new();
      alpha_sel     = ALPHA_STD;
      discarding    = 1'b0;
      mismatches    = 0;
      decoded_chars = 0;
      clear_group();
    endfunction

    function void clear_group();
      group_pos    = 2'd0;
      held_sextets = 18'd0;
      third_is_pad = 1'b0;
    endfunction

    function void set_alphabet(logic sel);
      alpha_sel = sel;
    endfunction

    function bit sextet_of(logic [7:0] c, output logic [5:0] sx);
      string tab;
      sx  = 6'd0;
      tab = (alpha_sel == ALPHA_PERM) ? PERM_ALPHA : STD_ALPHA;
      if (c == 8'd0 || c > ASCII_MAX) return 1'b0;
      for (int i = 0; i < 64; i++) begin
        if (tab[i] == c) begin
          sx = 6'(i);
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void push_error();
      dec_byte_t r;
      r.data_byte = 8'd0;
      r.error     = 1'b1;
      r.last      = 1'b1;
      expected_bytes.push_back(r);
    endfunction

    // Decodes one accepted character request and queues the bytes it yields.
    function void take_char(logic [7:0] c, logic msg_end);
      logic [5:0] sx;
      logic       hit;
      logic       is_pad;
      logic [7:0] bytes[3];
      int         nb;
      dec_byte_t  r;
      hit    = sextet_of(c, sx);
      is_pad = (c == PAD_CHAR);
      if (discarding) begin
        if (msg_end) begin
          discarding = 1'b0;
          clear_group();
        end
        return;
      end
      decoded_chars++;
      if (!(hit || (is_pad && group_pos >= 2'd2))) begin
        push_error();
        clear_group();
        discarding = !msg_end;
        return;
      end
      if (group_pos != 2'd3) begin
        case (group_pos)
          2'd0: held_sextets[17:12] = sx;
          2'd1: held_sextets[11:6]  = sx;
          default: begin
            held_sextets[5:0] = hit ? sx : 6'd0;
            third_is_pad      = is_pad;
          end
        endcase
        group_pos++;
        if (msg_end) begin
          push_error();
          clear_group();
        end
        return;
      end
      bytes[0] = {held_sextets[17:12], held_sextets[11:10]};
      bytes[1] = {held_sextets[9:6], held_sextets[5:2]};
      bytes[2] = {held_sextets[1:0], sx};
      nb = third_is_pad ? 1 : (is_pad ? 2 : 3);
      for (int i = 0; i < nb; i++) begin
        r.data_byte = bytes[i];
        r.error     = 1'b0;
        r.last      = msg_end && (i == nb - 1);
        expected_bytes.push_back(r);
      end
      clear_group();
    endfunction

    function void check_byte(dec_byte_t got);
      dec_byte_t exp;
      if (expected_bytes.size() == 0) begin
        $error("unexpected result: data_byte %0h error %0b last %0b",
               got.data_byte, got.error, got.last);
        mismatches++;
        return;
      end
      exp = expected_bytes.pop_front();
      if (got.data_byte !== exp.data_byte) begin
        $error("data_byte: expected %0h, got %0h", exp.data_byte, got.data_byte);
        mismatches++;
      end
      if (got.error !== exp.error) begin
        $error("error: expected %0b, got %0b", exp.error, got.error);
        mismatches++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0b, got %0b", exp.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  b64d_in_if  in_chan ();
  b64d_out_if out_chan ();
  b64d_cfg_if cfg_chan ();

  base64_stream_decoder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  byte_scoreboard sb = new();

  int burst_left    = 0;
  bit no_gaps       = 1'b0;
  bit hold_off_req  = 1'b0;
  int idle_cycles   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sampling in the active region of the edge sees pre-edge values.
  always @(posedge clk) begin
    dec_byte_t got;
    bit        moved;
    moved = 1'b0;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got.data_byte = out_chan.data_byte;
      got.error     = out_chan.error;
      got.last      = out_chan.last;
      sb.check_byte(got);
      moved = 1'b1;
    end
    if (rst_n && in_chan.valid && in_chan.ready) begin
      sb.take_char(in_chan.ch, in_chan.msg_end);
      moved = 1'b1;
    end
    if (rst_n && cfg_chan.valid && cfg_chan.ready) moved = 1'b1;
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $error("no request accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result side: stall pattern that changes density now and then, plus a long
  // hold-off on request from the stimulus.
  initial begin
    int stall_pct;
    int span;
    stall_pct = 0;
    span      = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (span == 0) begin
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 25;
            default: stall_pct = 60;
          endcase
          span = $urandom_range(20, 80);
        end
        span--;
        out_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic msg_end);
    int gap;
    if (burst_left == 0 && !no_gaps) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_chan.valid   <= 1'b1;
    in_chan.ch      <= c;
    in_chan.msg_end <= msg_end;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_text(input string s, input bit end_last);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], end_last && (i == s.len() - 1));
    end
  endtask

  // Advances the clock before the first check so that the request just accepted has been noted.
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (sb.expected_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_alphabet(input logic sel);
    cfg_chan.valid           <= 1'b1;
    cfg_chan.alphabet_select <= sel;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    sb.set_alphabet(sel);
  endtask

  function automatic logic [7:0] alpha_char();
    string tab;
    tab = (sb.alpha_sel == ALPHA_PERM) ? PERM_ALPHA : STD_ALPHA;
    return tab[$urandom_range(0, 63)];
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    logic [5:0] sx;
    case ($urandom_range(0, 3))
      0: c = 8'd0;
      1: c = 8'($urandom_range(128, 255));
      default: begin
        do c = 8'($urandom_range(1, 127));
        while (sb.sextet_of(c, sx) || c == PAD_CHAR);
      end
    endcase
    return c;
  endfunction

  // One message: mostly well-formed groups with random padding, the rest
  // truncated, corrupted, padded too early, or plain noise. A nonzero group
  // count forces a clean message of that length.
  task automatic send_message(input int n_groups);
    logic [7:0] msg[$];
    int         groups;
    int         form;
    int         kind;
    int         pos;
    int         cut;
    groups = n_groups;
    if (groups == 0) begin
      groups = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 3);
    end
    for (int g = 0; g < groups; g++) begin
      form = (g == groups - 1 || $urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 0;
      msg.push_back(alpha_char());
      msg.push_back(alpha_char());
      case (form)
        0: begin
          msg.push_back(alpha_char());
          msg.push_back(alpha_char());
        end
        1: begin
          msg.push_back(PAD_CHAR);
          msg.push_back(PAD_CHAR);
        end
        2: begin
          msg.push_back(alpha_char());
          msg.push_back(PAD_CHAR);
        end
        default: begin
          msg.push_back(PAD_CHAR);
          msg.push_back(alpha_char());
        end
      endcase
    end
    kind = (n_groups != 0) ? 0 : $urandom_range(0, 99);
    if (kind >= 70 && kind < 80) begin
      cut = $urandom_range(1, 3);
      repeat (cut) void'(msg.pop_back());
    end else if (kind >= 80 && kind < 90) begin
      pos = $urandom_range(0, msg.size() - 1);
      msg[pos] = bad_char();
    end else if (kind >= 90 && kind < 95) begin
      pos = 4 * $urandom_range(0, groups - 1) + $urandom_range(0, 1);
      msg[pos] = PAD_CHAR;
    end else if (kind >= 95) begin
      msg.delete();
      repeat ($urandom_range(1, 10)) msg.push_back(8'($urandom_range(0, 255)));
    end
    for (int i = 0; i < msg.size(); i++) begin
      send_char(msg[i], i == msg.size() - 1);
    end
  endtask

  initial begin
    int start_count;
    logic sel;
    rst_n                    <= 1'b0;
    in_chan.valid            <= 1'b0;
    in_chan.ch               <= 8'd0;
    in_chan.msg_end          <= 1'b0;
    cfg_chan.valid           <= 1'b0;
    cfg_chan.alphabet_select <= ALPHA_STD;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_alphabet(ALPHA_STD);
    send_text("TWFu", 1'b1);
    send_text("TQ==", 1'b1);
    // Padded group in the middle of a message, then pad followed by a character.
    send_text("TWE=", 1'b0);
    send_text("TQ=A", 1'b1);
    // Pad in the second position, then characters dropped until the end flag.
    send_text("A=", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char(8'h7F, 1'b1);
    send_char(PAD_CHAR, 1'b1);
    send_text("AB", 1'b1);
    send_char(8'h80, 1'b0);
    send_char("x", 1'b1);
    drain();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      sel = (phase % 2 == 0) ? ALPHA_PERM : ALPHA_STD;
      write_alphabet(sel);
      start_count = sb.decoded_chars;
      if (phase == 2) begin
        // Long receiver hold-off while a long clean message keeps coming.
        hold_off_req = 1'b1;
        no_gaps      = 1'b1;
        send_message(12);
        no_gaps      = 1'b0;
      end
      while (sb.decoded_chars - start_count < CHARS_PER_PHASE) begin
        send_message(0);
        if ($urandom_range(0, 15) == 0) drain();
      end
      drain();
    end

    if (sb.expected_bytes.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_bytes.size());
    end
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/b64d_pkg.sv
src/b64d_in_if.sv
src/b64d_out_if.sv
src/b64d_cfg_if.sv
src/b64d_front.sv
src/b64d_queue.sv
src/b64d_back.sv
src/base64_stream_decoder.sv
tb/sv/testbench.sv
